/* hw/rtl/rrd_pkg.sv */
// Shared types and constants of the row record deserialiser.
`default_nettype none

package rrd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned TYPES_W    = 32;
    localparam int unsigned COL_OUT_W  = 4;
    localparam int unsigned TYPE_SLOTS = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned TDATA_W    = 88;
    localparam int unsigned TUSER_W    = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TYPES = 1'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

    typedef enum logic [1:0] {
        KIND_INT32 = 2'd0,
        KIND_INT64 = 2'd1,
        KIND_BOOL  = 2'd2,
        KIND_TEXT  = 2'd3
    } t_kind;

    // Decode state apart from the column index.
    typedef struct packed {
        logic [LEN_W-1:0]   byte_pos;
        logic [VALUE_W-1:0] acc;
        logic [LEN_W-1:0]   pend_len;
        logic               in_text;
    } t_dec_state;

    // One result word.
    typedef struct packed {
        logic [COL_OUT_W-1:0] column_index;
        t_kind                column_kind;
        logic [VALUE_W-1:0]   field_value;
        logic [LEN_W-1:0]     text_length;
        logic                 empty_text;
        logic                 column_done;
        logic                 row_done;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/row_record_deserializer_core.sv */
// Top level of the schema-driven row record deserialiser.
`default_nettype none

// Row record deserialiser. Bytes of back-to-back rows arrive one word at a
// time on the slave stream; each row holds column_count columns whose types
// come from column_types (two bits per column, column i in bits 2i+1..2i:
// int32, int64, boolean, text). Numbers are little-endian and leave as one
// sign-extended 64-bit word once their last byte arrives; a boolean leaves as
// 0 or 1; a text column reads a 16-bit little-endian length and then leaves
// one word per payload byte, or a single empty marker if the length is zero.
// Header bytes and all but the last byte of a number give no word. The block
// takes one byte every cycle: the whole decode of a byte is a single pass of
// logic from the state registers into the result register, and the next byte
// enters in the same cycle as the sink takes the waiting word; a word that the
// sink holds off stalls the byte stream until it is taken. The word for an
// accepted byte is registered and appears in the next cycle. Write the
// configuration between rows; a register change takes effect on the next
// byte. Truncated rows are not detected.
module row_record_deserializer_core #(
    parameter int unsigned MAX_COLUMNS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rrd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rrd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Byte stream in
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [rrd_pkg::BYTE_W-1:0]       i_s_axis_tdata,  // [7:0] data_byte
    // Result stream out
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [3:0] column_index, [67:4] field_value, [83:68] text_length,
    // [84] column_done, [87:85] zero
    output logic [rrd_pkg::TDATA_W-1:0]           o_m_axis_tdata,
    // [1:0] column_kind, [2] empty_text
    output logic [rrd_pkg::TUSER_W-1:0]           o_m_axis_tuser,
    output logic                                  o_m_axis_tlast   // row_done
);
    import rrd_pkg::*;

    localparam int unsigned COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [COUNT_W-1:0] r_count;
    logic [TYPES_W-1:0] r_types;
    logic [COL_W-1:0]   r_col;
    t_dec_state         r_state;
    t_result            r_out;
    logic               r_out_valid;

    logic [COL_W-1:0]   n_col;
    t_dec_state         n_state;
    t_result            n_res;
    logic               n_res_valid;
    logic               s_fire;

    // Take a byte whenever the result register is free or drains this cycle.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    rrd_step #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_step (
        .i_col       (r_col),
        .i_state     (r_state),
        .i_byte      (i_s_axis_tdata),
        .i_count     (r_count),
        .i_types     (r_types),
        .o_col       (n_col),
        .o_state     (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_res)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
            r_types <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COLUMN_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                CFG_COLUMN_TYPES: r_types <= i_cfg_data[TYPES_W-1:0];
                default:          r_count <= r_count;
            endcase
        end
    end

    // Decode state: advance on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_state <= '0;
        end else if (s_fire) begin
            r_col   <= n_col;
            r_state <= n_state;
        end
    end

    // Result register: load a fresh word, or drop the old one once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire && n_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.column_done, r_out.text_length,
                              r_out.field_value, r_out.column_index};
    assign o_m_axis_tuser  = {r_out.empty_text, r_out.column_kind};
    assign o_m_axis_tlast  = r_out.row_done;

endmodule

`default_nettype wire

/* hw/rtl/rrd_step.sv */
// Next-state and result logic for one input byte of the row deserialiser.
`default_nettype none

module rrd_step #(
    parameter int unsigned MAX_COLUMNS = 16
) (
    input  wire logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] i_col,
    input  wire rrd_pkg::t_dec_state                                    i_state,
    input  wire logic [rrd_pkg::BYTE_W-1:0]                             i_byte,
    input  wire logic [rrd_pkg::COUNT_W-1:0]                            i_count,
    input  wire logic [rrd_pkg::TYPES_W-1:0]                            i_types,
    output logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0]      o_col,
    output rrd_pkg::t_dec_state                                         o_state,
    output logic                                                        o_res_valid,
    output rrd_pkg::t_result                                            o_res
);
    import rrd_pkg::*;

    localparam int unsigned COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [5:0]       col6;
    logic [5:0]       eff_count;
    logic             last_col;
    t_kind            kind;
    logic [LEN_W:0]   pos_inc;
    logic [3:0]       need;
    logic [LEN_W-1:0] hdr_len;
    logic [VALUE_W-1:0] acc_or;
    logic             finish;

    always_comb begin
        col6 = 6'(i_col);
        if (i_count == '0) begin
            eff_count = 6'd1;
        end else if (6'(i_count) > 6'(MAX_COLUMNS)) begin
            eff_count = 6'(MAX_COLUMNS);
        end else begin
            eff_count = 6'(i_count);
        end
        last_col = (col6 + 6'd1) >= eff_count;

        // Columns past the type register decode as 32-bit integers.
        if (col6 < 6'(TYPE_SLOTS)) begin
            kind = t_kind'(i_types[{col6[3:0], 1'b0} +: 2]);
        end else begin
            kind = KIND_INT32;
        end

        pos_inc = {1'b0, i_state.byte_pos} + 17'd1;
        need    = (kind == KIND_INT32) ? 4'd4 : 4'd8;
        hdr_len = {i_byte, i_state.acc[7:0]};
        acc_or  = i_state.acc | (VALUE_W'(i_byte) << {i_state.byte_pos[2:0], 3'b000});

        o_col       = i_col;
        o_state     = i_state;
        o_res_valid = 1'b0;
        finish      = 1'b0;

        o_res.column_index = col6[3:0];
        o_res.column_kind  = kind;
        o_res.field_value  = '0;
        o_res.text_length  = '0;
        o_res.empty_text   = 1'b0;
        o_res.column_done  = 1'b0;
        o_res.row_done     = 1'b0;

        unique case (kind)
            KIND_INT32, KIND_INT64: begin
                o_state.acc = acc_or;
                if (pos_inc < 17'(need)) begin
                    o_state.byte_pos = pos_inc[LEN_W-1:0];
                end else begin
                    finish = 1'b1;
                    if (kind == KIND_INT32) begin
                        o_res.field_value = {{32{acc_or[31]}}, acc_or[31:0]};
                    end else begin
                        o_res.field_value = acc_or;
                    end
                end
            end
            KIND_BOOL: begin
                finish            = 1'b1;
                o_res.field_value = VALUE_W'(i_byte != '0);
            end
            KIND_TEXT: begin
                if (!i_state.in_text) begin
                    if (i_state.byte_pos == '0) begin
                        // Hold the low length byte.
                        o_state.acc      = VALUE_W'(i_byte);
                        o_state.byte_pos = 16'd1;
                    end else begin
                        o_state.pend_len = hdr_len;
                        o_state.byte_pos = '0;
                        o_state.acc      = '0;
                        if (hdr_len != '0) begin
                            o_state.in_text = 1'b1;
                        end else begin
                            finish           = 1'b1;
                            o_res.empty_text = 1'b1;
                        end
                    end
                end else begin
                    o_res_valid       = 1'b1;
                    o_res.field_value = VALUE_W'(i_byte);
                    o_res.text_length = i_state.pend_len;
                    if (pos_inc < {1'b0, i_state.pend_len}) begin
                        o_state.byte_pos = pos_inc[LEN_W-1:0];
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            default: begin
                finish = 1'b0;
            end
        endcase

        if (finish) begin
            o_res_valid       = 1'b1;
            o_res.column_done = 1'b1;
            o_res.row_done    = last_col;
            o_state           = '0;
            o_col             = last_col ? '0 : COL_W'(col6 + 6'd1);
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the row record deserialiser core.
`timescale 1ns / 100ps

// The byte stream is fed from a backlog queue by a clocked driver; each byte
// accepted by the core is decoded at once by a local row decoder, which files
// the word it should produce in a queue of expected words. A clocked monitor
// takes every word leaving the core and compares it field by field with the
// oldest expected word. Stimulus runs in phases. Registers are only written
// when the core has gone quiet between phases. A phase either sends whole
// rows under a fresh schema (sometimes ending in a cut-off row), or sends raw
// noise, so that rewrites of the schema land in the middle of rows as well.
module tb;

    import rrd_pkg::*;

    localparam int MAX_COLS      = 16;
    localparam int ITEM_TARGET   = 1250;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 2_000_000;

    typedef logic [7:0] t_octet_q [$];

    // ---------------------------------------------------------------- clock, reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- core ports
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata  = '0;

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [TUSER_W-1:0]    m_tuser;
    logic                  m_tlast;

    row_record_deserializer_core #(
        .MAX_COLUMNS(MAX_COLS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    // ---------------------------------------------------------------- decoder state
    // Local copy of the schema registers, as last written.
    logic [COUNT_W-1:0] cnt_cfg   = COUNT_RESET;
    logic [TYPES_W-1:0] types_cfg = '0;

    // Row decoder state, cleared as after reset.
    logic [3:0]         col_q  = '0;
    logic [LEN_W-1:0]   pos_q  = '0;
    logic [VALUE_W-1:0] acc_q  = '0;
    logic [LEN_W-1:0]   plen_q = '0;
    logic               text_q = 1'b0;

    t_result  expected_words [$];
    t_octet_q byte_backlog;

    int  items_sent    = 0;
    int  words_checked = 0;
    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    bit  calm          = 1'b0;

    t_result want_word;

    // Clamp the column count: zero acts as one, anything past the limit as the limit.
    function automatic int eff_columns();
        int n;
        n = int'(cnt_cfg);
        if (n < 1) n = 1;
        if (n > MAX_COLS) n = MAX_COLS;
        return n;
    endfunction

    function automatic void emit_word(input logic [3:0] col, input t_kind kind,
                                      input logic [63:0] value, input logic [15:0] tlen,
                                      input logic empty, input logic done, input logic last);
        t_result w;
        w.column_index = col;
        w.column_kind  = kind;
        w.field_value  = value;
        w.text_length  = tlen;
        w.empty_text   = empty;
        w.column_done  = done;
        w.row_done     = last;
        expected_words = {expected_words, w};
    endfunction

    // Advance the row decoder by one accepted byte and file any word it gives.
    function automatic void decode_byte(input logic [7:0] b);
        logic [3:0]  col;
        t_kind       kind;
        logic [63:0] value;
        logic [15:0] tlen;
        logic        empty;
        logic        last;
        int          need;
        col   = col_q;
        // Sixteen type slots cover every 4-bit column, so no column falls past them.
        kind  = t_kind'(types_cfg[2*int'(col) +: 2]);
        value = '0;
        tlen  = '0;
        empty = 1'b0;
        last  = 1'b0;

        if (kind == KIND_INT32 || kind == KIND_INT64) begin
            need  = (kind == KIND_INT32) ? 4 : 8;
            acc_q = acc_q | ({56'd0, b} << (8 * (pos_q & 16'd7)));
            // Complete once the count is reached or passed (type may change mid-number).
            if (int'(pos_q) + 1 < need) begin
                pos_q = pos_q + 16'd1;
                return;
            end
            value = acc_q;
            if (kind == KIND_INT32) value = {{32{acc_q[31]}}, acc_q[31:0]};
        end else if (kind == KIND_BOOL) begin
            value = (b != 8'd0) ? 64'd1 : 64'd0;
        end else if (!text_q) begin
            // Length header: the first byte is held, any later byte completes it.
            if (pos_q == 16'd0) begin
                acc_q = {56'd0, b};
                pos_q = 16'd1;
                return;
            end
            plen_q = {b, acc_q[7:0]};
            pos_q  = '0;
            acc_q  = '0;
            if (plen_q != 16'd0) begin
                text_q = 1'b1;
                return;
            end
            empty = 1'b1;
        end else begin
            value = {56'd0, b};
            tlen  = plen_q;
            if (int'(pos_q) + 1 < int'(plen_q)) begin
                pos_q = pos_q + 16'd1;
                emit_word(col, kind, value, tlen, 1'b0, 1'b0, 1'b0);
                return;
            end
        end

        // Close the column; a column at or past the count wraps to the next row.
        pos_q  = '0;
        acc_q  = '0;
        plen_q = '0;
        text_q = 1'b0;
        if (int'(col_q) + 1 >= eff_columns()) begin
            col_q = '0;
            last  = 1'b1;
        end else begin
            col_q = col_q + 4'd1;
        end
        emit_word(col, kind, value, tlen, empty, 1'b1, last);
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ---------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (byte_backlog.size() != 0) begin
                    s_tdata  <= byte_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on word %0d, %s: got %h, want %h", words_checked, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with none expected", m_tdata[63:0], '0);
                end else begin
                    want_word = expected_words.pop_front();
                    if (m_tdata[3:0] !== want_word.column_index)
                        report_mismatch("column_index", m_tdata[3:0], want_word.column_index);
                    if (m_tuser[1:0] !== want_word.column_kind)
                        report_mismatch("column_kind", m_tuser[1:0], want_word.column_kind);
                    if (m_tdata[67:4] !== want_word.field_value)
                        report_mismatch("field_value", m_tdata[67:4], want_word.field_value);
                    if (m_tdata[83:68] !== want_word.text_length)
                        report_mismatch("text_length", m_tdata[83:68], want_word.text_length);
                    if (m_tuser[2] !== want_word.empty_text)
                        report_mismatch("empty_text", m_tuser[2], want_word.empty_text);
                    if (m_tdata[84] !== want_word.column_done)
                        report_mismatch("column_done", m_tdata[84], want_word.column_done);
                    if (m_tlast !== want_word.row_done)
                        report_mismatch("row_done", m_tlast, want_word.row_done);
                end
                words_checked++;
            end
            // Hold off the sink now and then.
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words outstanding",
                 cycle_count, expected_words.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus helpers
    task automatic push_byte(input logic [7:0] b);
        byte_backlog = {byte_backlog, b};
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_COLUMN_COUNT) cnt_cfg = data[COUNT_W-1:0];
        else types_cfg = data;
    endtask

    // Wait until every byte is in and every word is out, then let the core settle.
    task automatic drain();
        do @(negedge i_clk);
        while (byte_backlog.size() != 0 || s_tvalid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_number(input int nbytes);
        logic [63:0] sign_bit;
        int          r;
        sign_bit = 64'd1 << (8 * nbytes - 1);
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return sign_bit - 64'd1;
        if (r == 3) return sign_bit;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_flag();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'h01;
        if (r == 2) return 8'h80;
        if (r == 3) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_text_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 0;
        if (r < 75) return $urandom_range(1, 8);
        if (r < 98) return $urandom_range(9, 64);
        return $urandom_range(100, 400);
    endfunction

    // Encode one whole row under the schema now held.
    task automatic build_row(ref t_octet_q row);
        t_kind       k;
        logic [63:0] v;
        logic [15:0] len;
        for (int c = 0; c < eff_columns(); c++) begin
            k = t_kind'(types_cfg[2*c +: 2]);
            case (k)
                KIND_INT32: begin
                    v = pick_number(4);
                    for (int i = 0; i < 4; i++) row = {row, v[8*i +: 8]};
                end
                KIND_INT64: begin
                    v = pick_number(8);
                    for (int i = 0; i < 8; i++) row = {row, v[8*i +: 8]};
                end
                KIND_BOOL: begin
                    row = {row, pick_flag()};
                end
                default: begin
                    len = 16'(pick_text_len());
                    row = {row, len[7:0]};
                    row = {row, len[15:8]};
                    for (int i = 0; i < int'(len); i++)
                        row = {row, 8'($urandom_range(0, 255))};
                end
            endcase
        end
    endtask

    // Bring the decoder back to the start of a row: one int32 column finishes
    // whatever is half done within four bytes and wraps to column zero.
    task automatic realign();
        int n;
        if (col_q == '0 && pos_q == '0 && !text_q) return;
        write_reg(CFG_COLUMN_COUNT, 32'd1);
        write_reg(CFG_COLUMN_TYPES, 32'd0);
        n = (int'(pos_q) + 1 >= 4) ? 1 : 4 - int'(pos_q);
        @(negedge i_clk);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
        drain();
    endtask

    // Pick a schema; counts of zero and past the limit, and uniform types, come up often.
    task automatic random_schema();
        int          r;
        logic [31:0] cnt;
        logic [31:0] types;
        r = $urandom_range(0, 99);
        if (r < 8) cnt = 0;
        else if (r < 16) cnt = $urandom_range(17, 31);
        else if (r < 26) cnt = 16;
        else if (r < 40) cnt = $urandom_range(9, 15);
        else cnt = $urandom_range(1, 8);
        // Stray upper bits must be dropped by the core.
        if ($urandom_range(0, 1) == 1) cnt = ($urandom & ~32'h1F) | cnt;
        r = $urandom_range(0, 99);
        if (r < 10) types = 32'h0000_0000;
        else if (r < 20) types = 32'hFFFF_FFFF;
        else if (r < 30) types = 32'h5555_5555;
        else if (r < 40) types = 32'hAAAA_AAAA;
        else types = $urandom;
        if ($urandom_range(0, 9) != 0) write_reg(CFG_COLUMN_COUNT, cnt);
        if ($urandom_range(0, 9) != 0) write_reg(CFG_COLUMN_TYPES, types);
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        t_octet_q row;
        int       cut;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset schema is one int32 column: send the most negative int32.
        calm = 1'b1;
        @(negedge i_clk);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h80);
        drain();

        // Four columns: int64, boolean, text, text.
        write_reg(CFG_COLUMN_COUNT, 32'd4);
        write_reg(CFG_COLUMN_TYPES, {24'd0, KIND_TEXT, KIND_TEXT, KIND_BOOL, KIND_INT64});
        @(negedge i_clk);
        // Largest positive int64.
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h7F);
        // Any nonzero byte reads as true.
        push_byte(8'hFF);
        // Two-byte text.
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);
        // Empty text gives a lone marker.
        push_byte(8'h00);
        push_byte(8'h00);
        drain();

        // A count of zero acts as one: each boolean closes its own row.
        write_reg(CFG_COLUMN_COUNT, 32'd0);
        write_reg(CFG_COLUMN_TYPES, {30'd0, KIND_BOOL});
        @(negedge i_clk);
        push_byte(8'h00);
        push_byte(8'h01);
        drain();

        while (items_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 80) begin
                // Well-formed rows, usually from a clean row boundary.
                if ($urandom_range(0, 99) < 85) realign();
                random_schema();
                @(negedge i_clk);
                repeat ($urandom_range(1, 5)) begin
                    // Stop adding rows once the byte budget is spent.
                    if (items_sent < ITEM_TARGET) begin
                        row.delete();
                        build_row(row);
                        foreach (row[i]) push_byte(row[i]);
                    end
                end
                // Leave a row cut short so the next schema lands mid-row.
                if ($urandom_range(0, 3) == 0) begin
                    row.delete();
                    build_row(row);
                    if (row.size() > 1) begin
                        cut = $urandom_range(1, row.size() - 1);
                        for (int i = 0; i < cut; i++) push_byte(row[i]);
                    end
                end
            end else begin
                // Raw noise under whatever schema comes up.
                random_schema();
                @(negedge i_clk);
                repeat ($urandom_range(4, 40)) push_byte(8'($urandom_range(0, 255)));
            end
            drain();
        end

        drain();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
